>>> rtl/core/mcst_pkg.sv
// Shared types and constants for the timer channel table.
// Used by mcst_ctrl, mcst_dpath and multi_channel_software_timer_table.
package mcst_pkg;

  // Default table size and idle wait reset value
  localparam int DEF_CHANNELS    = 16;
  localparam logic [31:0] IDLE_WAIT_RESET = 32'(10 * 1000);

  // Command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Result kinds
  localparam logic KIND_FIRE   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  channel;
    logic [30:0] first_delay_ms;
    logic [30:0] period_ms;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  fired_channel;
    logic [31:0] elapsed_ms;
    logic [31:0] next_wait_ms;
    logic        last;
  } out_item_t;

  // Per-channel timer entry held in the table memory
  typedef struct packed {
    logic [31:0] elapsed;
    logic [31:0] wake;
    logic [30:0] period;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic take;    // input transaction accepted this cycle
    logic walk;    // walk the channel table
    logic report;  // load the end-of-tick report
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_tick;    // tick command present on input
    logic walk_done;  // all channels visited, pipeline drained
    logic out_free;   // output register can take a result
  } ctl_sts_t;

endpackage

>>> rtl/core/multi_channel_software_timer_table.sv
// Top level of the timer channel table.
// Depends on mcst_pkg, mcst_ctrl and mcst_dpath.
//
// Usage:
//   in channel  (in_valid/in_stall/in_data): start, stop or tick commands.
//     A transaction is taken when in_valid is high and in_stall is low.
//   out channel (out_valid/out_stall/out_data): one result per fired
//     channel, in channel index order, then a wait report with last set.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes idle_wait_ms;
//     cfg_ready is always high. Write only while the table is idle.
// Command flow:
//   start and stop take effect at the accepting edge and produce nothing;
//   the next command can follow in the next cycle.
//   A tick walks the entry memory one channel per cycle through a two-stage
//   read/update pipeline, then issues the report; the walk pauses while a
//   fired channel waits for the output register.
//   A stalled output register holds its result; in_stall stays high until
//   the report is loaded.
// Reset: all channels disarmed, idle_wait_ms = 10000, output empty.
module multi_channel_software_timer_table #(
  parameter int CHANNELS = mcst_pkg::DEF_CHANNELS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mcst_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mcst_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  import mcst_pkg::*;

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  mcst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  mcst_dpath #(.CHANNELS(CHANNELS)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

>>> rtl/core/mcst_ctrl.sv
// Controller state machine for the timer channel table.
// Depends on mcst_pkg; drives mcst_dpath through ctl_cmd_t.
module mcst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mcst_pkg::ctl_sts_t sts,
  output mcst_pkg::ctl_cmd_t ctl
);
  import mcst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_REPORT = 3'b100
  } state_t;

  state_t state, state_next;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid && sts.in_tick) state_next = S_WALK;
      S_WALK:   if (sts.walk_done) state_next = S_REPORT;
      S_REPORT: if (sts.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Commands
  assign in_stall   = (state != S_IDLE);
  assign ctl.take   = in_valid && (state == S_IDLE);
  assign ctl.walk   = (state == S_WALK);
  assign ctl.report = (state == S_REPORT);

endmodule

>>> rtl/core/mcst_dpath.sv
// Datapath for the timer channel table: entry memory, armed bits, walk
// pipeline, minimum tracker and output register. Depends on mcst_pkg.
module mcst_dpath #(
  parameter int CHANNELS = mcst_pkg::DEF_CHANNELS
) (
  input  logic                clk,
  input  logic                rst,
  input  mcst_pkg::in_item_t  in_data,
  input  logic                cfg_valid,
  input  logic [31:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mcst_pkg::out_item_t out_data,
  input  mcst_pkg::ctl_cmd_t  ctl,
  output mcst_pkg::ctl_sts_t  sts
);
  import mcst_pkg::*;

  localparam int IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IW1 = $clog2(CHANNELS + 1);

  entry_t              mem [CHANNELS];
  logic [CHANNELS-1:0] armed;
  logic [31:0]         idle_wait;

  logic [IW1-1:0] rd_idx;
  entry_t         rd_word;
  logic           p_valid;
  logic [IW-1:0]  p_idx;
  logic           m_valid;
  logic [31:0]    m_rem;
  logic           any;
  logic [31:0]    best;

  logic           ch_ok, is_start, is_stop, tick_start;
  logic [IW-1:0]  ch_idx;
  logic           all_issued, out_free, advance, issue, p_go;
  logic           p_armed, fire, p_emit, reload;
  logic [31:0]    inc;
  logic           we;
  logic [IW-1:0]  waddr;
  entry_t         wdata;

  // Input decode
  assign ch_ok      = 7'(in_data.channel) < 7'(CHANNELS);
  assign ch_idx     = IW'(in_data.channel);
  assign is_start   = ctl.take && (in_data.cmd == CMD_START) && ch_ok;
  assign is_stop    = ctl.take && (in_data.cmd == CMD_STOP) && ch_ok;
  assign tick_start = ctl.take && (in_data.cmd == CMD_TICK);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst)            idle_wait <= IDLE_WAIT_RESET;
    else if (cfg_valid) idle_wait <= cfg_data;
  end

  // Walk stage: registered entry word, update and fire check
  assign p_armed = armed[p_idx];
  assign inc     = (rd_word.elapsed == '1) ? rd_word.elapsed : rd_word.elapsed + 32'd1;
  assign fire    = inc > rd_word.wake;
  assign p_emit  = p_valid && p_armed && fire;
  assign reload  = rd_word.period != '0;

  assign out_free   = !out_valid || !out_stall;
  assign all_issued = (rd_idx == IW1'(CHANNELS));
  assign advance    = !(p_emit && !out_free);
  assign issue      = ctl.walk && advance && !all_issued;
  assign p_go       = ctl.walk && advance && p_valid;

  // Read side of the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      p_valid <= 1'b0;
    end else if (tick_start) begin
      rd_idx  <= '0;
      p_valid <= 1'b0;
    end else if (ctl.walk && advance) begin
      p_valid <= issue;
      if (issue) rd_idx <= rd_idx + IW1'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_idx   <= rd_idx[IW-1:0];
      rd_word <= mem[rd_idx[IW-1:0]];
    end
  end

  // Single write port: start command or walk write-back
  always_comb begin
    we    = is_start || (p_go && p_armed);
    waddr = p_idx;
    wdata = '{elapsed: inc, wake: rd_word.wake, period: rd_word.period};
    if (is_start) begin
      waddr = ch_idx;
      wdata = '{elapsed: 32'd0, wake: {1'b0, in_data.first_delay_ms},
                period: in_data.period_ms};
    end else if (fire) begin
      wdata = '{elapsed: 32'd0, wake: {1'b0, rd_word.period}, period: rd_word.period};
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Armed bits
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
    end else begin
      if (is_start) armed[ch_idx] <= 1'b1;
      if (is_stop)  armed[ch_idx] <= 1'b0;
      if (p_go && p_emit && !reload) armed[p_idx] <= 1'b0;
    end
  end

  // Remaining time stage, then running minimum
  always_ff @(posedge clk) begin
    if (rst) m_valid <= 1'b0;
    else     m_valid <= p_go && p_armed && (!fire || reload);
  end

  always_ff @(posedge clk) begin
    if (p_go) m_rem <= fire ? {1'b0, rd_word.period} : rd_word.wake - inc;
  end

  always_ff @(posedge clk) begin
    if (rst || tick_start) begin
      any <= 1'b0;
    end else if (m_valid && (!any || m_rem < best)) begin
      any <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_valid && (!any || m_rem < best)) best <= m_rem;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((p_go && p_emit) || (ctl.report && out_free)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_go && p_emit) begin
      out_data <= '{kind: KIND_FIRE, fired_channel: 4'(p_idx), elapsed_ms: inc,
                    next_wait_ms: 32'd0, last: 1'b0};
    end else if (ctl.report && out_free) begin
      out_data <= '{kind: KIND_REPORT, fired_channel: 4'd0, elapsed_ms: 32'd0,
                    next_wait_ms: any ? best : idle_wait, last: 1'b1};
    end
  end

  // Status
  assign sts.in_tick   = in_data.cmd == CMD_TICK;
  assign sts.walk_done = all_issued && !p_valid && !m_valid;
  assign sts.out_free  = out_free;

  // Checks
  a_report_drained: assert property (@(posedge clk) disable iff (rst)
    ctl.report |-> !p_valid && !m_valid)
    else $error("report while walk pipeline busy");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    rd_idx <= IW1'(CHANNELS))
    else $error("walk index out of range");
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    p_go && p_emit |-> out_free)
    else $error("fire result dropped");
  a_tick_init: assert property (@(posedge clk) disable iff (rst)
    tick_start |=> !any && rd_idx == '0 && !p_valid)
    else $error("tick did not restart walk");

endmodule

>>> dv/multi_channel_software_timer_table_tb.sv
// Self-checking testbench for the timer channel table: directed and random command
// streams with stalls on both sides, checked against an in-bench table predictor.
// Depends on mcst_pkg and multi_channel_software_timer_table.
module multi_channel_software_timer_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcst_pkg::*;

  // Command code the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NCH = DEF_CHANNELS;
  // Cycles to let the table finish a walk before a config write or the end
  localparam int SETTLE_CYCLES = 40;

  // Timer table predictor plus the queue of results it still owes
  class timer_table_sb;
    bit          ch_armed   [NCH];
    logic [31:0] ch_elapsed [NCH];
    logic [31:0] ch_wake    [NCH];
    logic [30:0] ch_period  [NCH];
    logic [31:0] idle_wait;
    out_item_t   due_results[$];
    int          errors;

    function new();
      for (int i = 0; i < NCH; i++) begin
        ch_armed[i]   = 1'b0;
        ch_elapsed[i] = '0;
        ch_wake[i]    = '0;
        ch_period[i]  = '0;
      end
      idle_wait = IDLE_WAIT_RESET;
      errors = 0;
    endfunction

    // Apply one accepted command to the table and queue what it should produce
    function void note_command(in_item_t item);
      out_item_t   res;
      logic [31:0] best;
      logic [31:0] left;
      bit          found;
      found = 1'b0;
      best = '0;
      case (item.cmd)
        CMD_START: begin
          if (item.channel < NCH) begin
            ch_armed[item.channel]   = 1'b1;
            ch_elapsed[item.channel] = '0;
            ch_wake[item.channel]    = {1'b0, item.first_delay_ms};
            ch_period[item.channel]  = item.period_ms;
          end
        end
        CMD_STOP: begin
          if (item.channel < NCH) ch_armed[item.channel] = 1'b0;
        end
        CMD_TICK: begin
          // advance and fire in index order
          for (int i = 0; i < NCH; i++) begin
            if (ch_armed[i]) begin
              if (ch_elapsed[i] != '1) ch_elapsed[i] = ch_elapsed[i] + 1;
              if (ch_elapsed[i] > ch_wake[i]) begin
                res.kind          = KIND_FIRE;
                res.fired_channel = 4'(i);
                res.elapsed_ms    = ch_elapsed[i];
                res.next_wait_ms  = '0;
                res.last          = 1'b0;
                due_results = {due_results, res};
                if (ch_period[i] != '0) begin
                  ch_elapsed[i] = '0;
                  ch_wake[i]    = {1'b0, ch_period[i]};
                end else begin
                  ch_armed[i] = 1'b0;
                end
              end
            end
          end
          // least remaining time over what is still armed
          for (int i = 0; i < NCH; i++) begin
            if (ch_armed[i]) begin
              left = (ch_wake[i] >= ch_elapsed[i]) ? ch_wake[i] - ch_elapsed[i] : '0;
              if (!found || left < best) begin
                best  = left;
                found = 1'b1;
              end
            end
          end
          res.kind          = KIND_REPORT;
          res.fired_channel = '0;
          res.elapsed_ms    = '0;
          res.next_wait_ms  = found ? best : idle_wait;
          res.last          = 1'b1;
          due_results = {due_results, res};
        end
        default: ;  // unused command: no effect
      endcase
    endfunction

    function void flag_field(string name, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    endfunction

    // Compare one accepted result against the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual %h", $time, got);
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind) flag_field("kind", want.kind, got.kind);
      if (got.fired_channel !== want.fired_channel)
        flag_field("fired_channel", want.fired_channel, got.fired_channel);
      if (got.elapsed_ms !== want.elapsed_ms)
        flag_field("elapsed_ms", want.elapsed_ms, got.elapsed_ms);
      if (got.next_wait_ms !== want.next_wait_ms)
        flag_field("next_wait_ms", want.next_wait_ms, got.next_wait_ms);
      if (got.last !== want.last) flag_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  int send_idle_pct;
  int recv_stall_pct;
  timer_table_sb sb;

  multi_channel_software_timer_table u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: check each accepted transaction, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic in_item_t make_cmd(logic [1:0] cmd, logic [3:0] ch,
                                        logic [30:0] first, logic [30:0] period);
    in_item_t item;
    item.cmd            = cmd;
    item.channel        = ch;
    item.first_delay_ms = first;
    item.period_ms      = period;
    return item;
  endfunction

  // Mostly short timers so channels fire often; a few full-range values
  function automatic in_item_t rand_command();
    in_item_t item;
    int       pick;
    pick = $urandom_range(99);
    item = make_cmd(CMD_TICK, 4'($urandom_range(15)), 31'($urandom), 31'($urandom));
    if (pick < 80 && pick >= 45) begin
      item.cmd = CMD_START;
      if ($urandom_range(9) != 0) begin
        item.first_delay_ms = 31'($urandom_range(6));
        item.period_ms = ($urandom_range(2) == 0) ? '0 : 31'($urandom_range(5, 1));
      end
    end else if (pick >= 80 && pick < 97) begin
      item.cmd = CMD_STOP;
    end else if (pick >= 97) begin
      item.cmd = CMD_UNUSED;
    end
    return item;
  endfunction

  // Offer one command transaction, with optional idle cycles before it
  task automatic send_item(in_item_t item);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sb.note_command(item);
  endtask

  // Hold off input until every owed result is back and the walk is over
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_idle_wait(logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.idle_wait = value;
  endtask

  task automatic run_directed();
    // tick with nothing armed reports the reset idle wait
    send_item(make_cmd(CMD_TICK, 4'd0, '0, '0));
    send_item(make_cmd(CMD_UNUSED, 4'hF, '1, '1));
    send_item(make_cmd(CMD_STOP, 4'd9, '0, '0));
    send_item(make_cmd(CMD_START, 4'd15, '1, '1));
    // restart of an armed channel replaces its settings
    send_item(make_cmd(CMD_START, 4'd5, 31'd2, 31'd1));
    send_item(make_cmd(CMD_START, 4'd5, 31'd1, 31'd3));
    send_item(make_cmd(CMD_TICK, 4'd0, '0, '0));
    send_item(make_cmd(CMD_TICK, 4'd0, '0, '0));
    // every channel due on the same tick: one-shot on even, periodic on odd
    for (int i = 0; i < NCH; i++)
      send_item(make_cmd(CMD_START, 4'(i), '0, 31'(i % 2)));
    send_item(make_cmd(CMD_TICK, 4'd0, '0, '0));
    send_item(make_cmd(CMD_TICK, 4'd0, '0, '0));
  endtask

  task automatic run_random(int count);
    in_item_t item;
    int       sent;
    sent = 0;
    while (sent < count) begin
      item = rand_command();
      send_item(item);
      sent++;
    end
  endtask

  // Main sequence
  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    settle();

    write_idle_wait(32'h0);
    send_idle_pct  = 8;
    recv_stall_pct = 63;
    run_random(68);
    settle();

    write_idle_wait(32'hFFFF_FFFF);
    send_idle_pct  = 63;
    recv_stall_pct = 8;
    run_random(68);
    settle();

    write_idle_wait($urandom);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(68);
    settle();

    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
